>>> design/sbox_differential_uniformity_assert.svh
// Assertion macros used by the checker of the S-box uniformity block.
`ifndef SBOX_DIFFERENTIAL_UNIFORMITY_ASSERT_SVH
`define SBOX_DIFFERENTIAL_UNIFORMITY_ASSERT_SVH

// Check a property on every rising edge outside of reset.
`define SDU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sdu check failed");

// Check a property on every rising edge, reset included.
`define SDU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("sdu check failed during or after reset");

`endif

>>> design/sdu_pkg.sv
// Shared types and constants of the S-box differential uniformity block.
`timescale 1ns / 1ps

package sdu_pkg;

  localparam int MaxInBitsDef  = 8;
  localparam int MaxOutBitsDef = 8;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;
  localparam int EntryW   = 8;
  localparam int UnifW    = 9;
  localparam int RowsW    = 8;

  localparam logic [CfgIdxW-1:0]  RegInBits  = 2'd0;
  localparam logic [CfgIdxW-1:0]  RegOutBits = 2'd1;
  localparam logic [CfgDataW-1:0] CfgReset   = 4'd8;

  localparam logic [UnifW-1:0] UnifMax = 9'h1FF;
  localparam logic [RowsW-1:0] RowsMax = 8'hFF;

  // Operation handed to the histogram memory.
  typedef struct packed {
    logic inc;    // count one more pair at the given bin
    logic scan;   // read a bin out and zero it
    logic clear;  // zero a bin without reading it
  } hist_cmd_t;

  // Status returned by the histogram memory.
  typedef struct packed {
    logic busy;      // an increment is still in flight
    logic bin_vld;   // a scanned bin count is on bin_cnt
    logic bin_zero;  // the scanned bin is output difference zero
  } hist_stat_t;

endpackage

>>> design/sbox_differential_uniformity.sv
// Top level: S-box load, difference table walk and result register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | entry_i
//   out     | out       | out_valid_o/out_ready_i | uniformity_o, zero_diff_rows_o
//
// Entries load at one per cycle into the S-box store. The last entry starts the
// walk: per nonzero input difference, pair reads through the histogram
// read-modify-write, a drain, a scan of every bin and a row end; then the
// result is posted.
// After reset a clearing pass zeroes the histogram, with no request accepted
// on in. Configuration requests are always taken.
// A result waiting on out stalls only the post of the next result.
`timescale 1ns / 1ps

module sbox_differential_uniformity #(
  parameter int MAX_IN_BITS  = sdu_pkg::MaxInBitsDef,
  parameter int MAX_OUT_BITS = sdu_pkg::MaxOutBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sdu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sdu_pkg::EntryW-1:0]   entry_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sdu_pkg::UnifW-1:0]    uniformity_o,
  output logic [sdu_pkg::RowsW-1:0]    zero_diff_rows_o
);
  import sdu_pkg::*;

  localparam int IW   = MAX_IN_BITS;
  localparam int OW   = MAX_OUT_BITS;
  localparam int CW   = MAX_IN_BITS + 1;
  localparam int UW   = (CW > UnifW) ? CW : UnifW;
  localparam int RW   = (IW > RowsW) ? IW : RowsW;
  localparam int ExtW = EntryW + OW;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_PAIRS  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_ROWEND = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [CfgDataW-1:0] in_bits_q, in_bits_d;
  logic [CfgDataW-1:0] out_bits_q, out_bits_d;
  logic [IW-1:0]       load_q, load_d;
  logic [IW-1:0]       x_q, x_d;
  logic [IW-1:0]       a_q, a_d;
  logic [OW-1:0]       b_q, b_d;
  logic [CW-1:0]       best_q, best_d;
  logic [IW-1:0]       tally_q, tally_d;
  logic                p1_q, p1_d;
  logic                out_vld_q, out_vld_d;
  logic [UnifW-1:0]    unif_q, unif_d;
  logic [RowsW-1:0]    rows_q, rows_d;

  logic [CfgDataW-1:0] ib, ob;
  logic [IW-1:0]       in_mask;
  logic [OW-1:0]       out_mask;
  logic [ExtW-1:0]     entry_ext;
  logic [OW-1:0]       entry_word;
  logic                st_we;
  logic [OW-1:0]       st_rd_a, st_rd_b;
  logic [OW-1:0]       pair_diff;
  hist_cmd_t           hcmd;
  logic [OW-1:0]       haddr;
  hist_stat_t          hstat;
  logic [CW-1:0]       bin_cnt;
  logic [UW-1:0]       best_ext;
  logic [RW-1:0]       tally_ext;
  logic                in_acc, cfg_acc;

  // Clamp widths in use and build the index and word masks.
  always_comb begin
    if (in_bits_q == '0) begin
      ib = CfgDataW'(1);
    end else if (in_bits_q > CfgDataW'(MAX_IN_BITS)) begin
      ib = CfgDataW'(MAX_IN_BITS);
    end else begin
      ib = in_bits_q;
    end
    if (out_bits_q == '0) begin
      ob = CfgDataW'(1);
    end else if (out_bits_q > CfgDataW'(MAX_OUT_BITS)) begin
      ob = CfgDataW'(MAX_OUT_BITS);
    end else begin
      ob = out_bits_q;
    end
  end

  assign in_mask    = ~({IW{1'b1}} << ib);
  assign out_mask   = ~({OW{1'b1}} << ob);
  assign entry_ext  = ExtW'(entry_i);
  assign entry_word = entry_ext[OW-1:0] & out_mask;
  assign pair_diff  = st_rd_a ^ st_rd_b;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_LOAD);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // Widen results to a common width for the saturation on post.
  assign best_ext  = UW'(best_q);
  assign tally_ext = RW'(tally_q);

  // Sequence the clearing pass, load, pair walk, drain, scan and result post.
  always_comb begin
    state_d    = state_q;
    in_bits_d  = in_bits_q;
    out_bits_d = out_bits_q;
    load_d     = load_q;
    x_d        = x_q;
    a_d        = a_q;
    b_d        = b_q;
    best_d     = best_q;
    tally_d    = tally_q;
    p1_d       = 1'b0;
    out_vld_d  = out_vld_q && !out_ready_i;
    unif_d     = unif_q;
    rows_d     = rows_q;
    hcmd       = '0;
    haddr      = b_q;
    st_we      = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        hcmd.clear = 1'b1;
        b_d        = b_q + OW'(1);
        if (b_q == {OW{1'b1}}) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (in_acc) begin
          st_we = 1'b1;
          if (load_q == in_mask) begin
            load_d  = '0;
            x_d     = '0;
            a_d     = IW'(1);
            best_d  = '0;
            tally_d = '0;
            state_d = S_PAIRS;
          end else begin
            load_d = load_q + IW'(1);
          end
        end
      end
      S_PAIRS: begin
        p1_d = 1'b1;
        x_d  = x_q + IW'(1);
        if (x_q == in_mask) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_q && !hstat.busy) begin
          b_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        hcmd.scan = 1'b1;
        b_d       = b_q + OW'(1);
        if (b_q == out_mask) begin
          state_d = S_ROWEND;
        end
      end
      S_ROWEND: begin
        if (a_q == in_mask) begin
          state_d = S_DONE;
        end else begin
          a_d     = a_q + IW'(1);
          x_d     = '0;
          state_d = S_PAIRS;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          unif_d    = (best_ext > UW'(UnifMax)) ? UnifMax : best_ext[UnifW-1:0];
          rows_d    = (tally_ext > RW'(RowsMax)) ? RowsMax : tally_ext[RowsW-1:0];
          state_d   = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // Count the pair whose store reads just returned.
    if (p1_q) begin
      hcmd.inc = 1'b1;
      haddr    = pair_diff;
    end

    // Fold a scanned bin into the running maximum or the zero-row tally.
    if (hstat.bin_vld) begin
      if (hstat.bin_zero) begin
        if (bin_cnt != '0) begin
          tally_d = tally_q + IW'(1);
        end
      end else if (bin_cnt > best_q) begin
        best_d = bin_cnt;
      end
    end

    // Write a register and restart the load.
    if (cfg_acc) begin
      unique case (cfg_index_i)
        RegInBits: begin
          in_bits_d = cfg_data_i;
          load_d    = '0;
        end
        RegOutBits: begin
          out_bits_d = cfg_data_i;
          load_d     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      in_bits_q  <= CfgReset;
      out_bits_q <= CfgReset;
      load_q     <= '0;
      x_q        <= '0;
      a_q        <= '0;
      b_q        <= '0;
      best_q     <= '0;
      tally_q    <= '0;
      p1_q       <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_bits_q  <= in_bits_d;
      out_bits_q <= out_bits_d;
      load_q     <= load_d;
      x_q        <= x_d;
      a_q        <= a_d;
      b_q        <= b_d;
      best_q     <= best_d;
      tally_q    <= tally_d;
      p1_q       <= p1_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    unif_q <= unif_d;
    rows_q <= rows_d;
  end

  sdu_store #(
    .AW(IW),
    .DW(OW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (st_we),
    .wr_addr_i  (load_q),
    .wr_data_i  (entry_word),
    .rd_addr_a_i(x_q),
    .rd_addr_b_i(x_q ^ a_q),
    .rd_data_a_o(st_rd_a),
    .rd_data_b_o(st_rd_b)
  );

  sdu_hist #(
    .AW(OW),
    .CW(CW)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (hcmd),
    .addr_i   (haddr),
    .stat_o   (hstat),
    .bin_cnt_o(bin_cnt)
  );

  assign out_valid_o      = out_vld_q;
  assign uniformity_o     = unif_q;
  assign zero_diff_rows_o = rows_q;

endmodule

>>> design/sdu_store.sv
// S-box store: one write port, two registered read ports.
`timescale 1ns / 1ps

module sdu_store #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_a_i,
  input  logic [AW-1:0] rd_addr_b_i,
  output logic [DW-1:0] rd_data_a_o,
  output logic [DW-1:0] rd_data_b_o
);
  import sdu_pkg::*;

  localparam int Depth = 1 << AW;

  logic [DW-1:0] mem_q [Depth];

  // Write one entry, read two.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

>>> design/sdu_hist.sv
// Row histogram: read-modify-write counter memory with scan and clear.
`timescale 1ns / 1ps

module sdu_hist #(
  parameter int AW = 8,
  parameter int CW = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdu_pkg::hist_cmd_t  cmd_i,
  input  logic [AW-1:0]       addr_i,
  output sdu_pkg::hist_stat_t stat_o,
  output logic [CW-1:0]       bin_cnt_o
);
  import sdu_pkg::*;

  localparam int Depth = 1 << AW;

  logic [CW-1:0] mem_q [Depth];
  logic [CW-1:0] rdata_q;

  hist_cmd_t     op2_q;
  logic [AW-1:0] addr2_q;
  logic          wr_vld_q;
  logic [AW-1:0] wr_addr_q;
  logic [CW-1:0] wr_data_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [CW-1:0] base;

  // Forward the write of the previous cycle, which the memory read missed.
  assign base = (wr_vld_q && (wr_addr_q == addr2_q)) ? wr_data_q : rdata_q;

  // Pick the write: finishing increment or scan first, then a plain clear.
  always_comb begin
    we    = 1'b0;
    waddr = addr2_q;
    wdata = '0;
    priority if (op2_q.inc) begin
      we    = 1'b1;
      wdata = base + CW'(1);
    end else if (op2_q.scan) begin
      we    = 1'b1;
    end else if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = addr_i;
    end
  end

  // Memory array with a registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[addr_i];
  end

  // Register the increment and scan commands for their write stage; a clear is not tracked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op2_q    <= '0;
      wr_vld_q <= 1'b0;
    end else begin
      op2_q    <= '{inc: cmd_i.inc, scan: cmd_i.scan, clear: 1'b0};
      wr_vld_q <= we;
    end
  end

  // Hold address and last write for forwarding.
  always_ff @(posedge clk_i) begin
    addr2_q   <= addr_i;
    wr_addr_q <= waddr;
    wr_data_q <= wdata;
  end

  assign stat_o.busy     = op2_q.inc;
  assign stat_o.bin_vld  = op2_q.scan;
  assign stat_o.bin_zero = (addr2_q == '0);
  assign bin_cnt_o       = base;

endmodule

>>> design/sdu_checker.sv
// Port-level checker of the S-box uniformity block and its bind.
`timescale 1ns / 1ps
`include "sbox_differential_uniformity_assert.svh"

module sdu_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_ready_o,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [sdu_pkg::UnifW-1:0] uniformity_o,
  input logic [sdu_pkg::RowsW-1:0] zero_diff_rows_o
);
  import sdu_pkg::*;

  // No result is shown on the edge after reset is seen.
  `SDU_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !out_valid_o)

  // A result stays offered until taken.
  `SDU_ASSERT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // A stalled result keeps its payload.
  `SDU_ASSERT(a_out_stable, clk_i, rst_ni,
              out_valid_o && !out_ready_i |=> $stable(uniformity_o) && $stable(zero_diff_rows_o))

  // Posting a result returns the block to loading.
  `SDU_ASSERT(a_post_to_load, clk_i, rst_ni, $rose(out_valid_o) |-> in_ready_o && cfg_ready_o)

  // A result never follows an accepted entry in the next cycle.
  `SDU_ASSERT(a_no_instant_result, clk_i, rst_ni, in_valid_i && in_ready_o |=> !$rose(out_valid_o))

endmodule

bind sbox_differential_uniformity sdu_checker u_sdu_checker (.*);
